### design/cvf_pkg.sv
// shared types and constants for the cell voltage filter and fault block
// no dependencies

package cvf_pkg;

  localparam int NUM_CELLS_DEF = 8;

  localparam int CELL_W   = 3;
  localparam int ADC_W    = 10;
  localparam int FRAC_W   = 8;
  localparam int AVG_W    = ADC_W + FRAC_W;
  localparam int ALPHA_W  = 9;
  localparam int CFG_W    = AVG_W;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd64;
  localparam logic [AVG_W-1:0]   LOW_TH_RESET  = 18'd0;
  localparam logic [AVG_W-1:0]   HIGH_TH_RESET = 18'd261888;
  localparam logic [AVG_W-1:0]   AVG_MAX       = 18'd261888;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TH   = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic              in_range;
    logic [AVG_W-1:0]  sample_q;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [AVG_W-1:0]   low_th;
    logic [AVG_W-1:0]   high_th;
  } cfg_t;

endpackage

### design/cvf_ram.sv
// generic single write port ram with registered read
// no dependencies

module cvf_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cvf_front.sv
// input side: accepts stream transfers, checks the cell index and scales the sample
// depends on cvf_pkg

module cvf_front import cvf_pkg::*; #(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 q_full,
  output logic                 push,
  output item_t                push_item
);

  logic [CELL_W-1:0] cell_num;
  logic [ADC_W-1:0]  adc;

  assign cell_num = s_tdata[CELL_W-1:0];
  assign adc      = s_tdata[CELL_W+ADC_W-1:CELL_W];
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_item.cell_id  = cell_num;
    push_item.in_range = (32'(cell_num) < NUM_CELLS);
    push_item.sample_q = {adc, {FRAC_W{1'b0}}};
  end

endmodule

### design/cvf_queue.sv
// two entry queue between the input side and the filter side
// depends on cvf_pkg

module cvf_queue import cvf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of bounds");

endmodule

### design/cvf_back.sv
// filter side: per cell moving average update, window compare, fault marks, output register
// depends on cvf_pkg and cvf_ram

module cvf_back import cvf_pkg::*; #(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  head_valid,
  input  item_t                 head_item,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int EXT_W = (IDX_W > CELL_W) ? IDX_W : CELL_W;
  localparam int PROD_W = AVG_W + ALPHA_W + 2;

  logic             s1_valid;
  item_t            s1_item;
  logic             byp;
  logic [AVG_W-1:0] byp_data;
  logic             old_valid;
  logic             s1_fire;
  logic             s1_load;

  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] s1_idx;
  logic [EXT_W-1:0] head_ext;
  logic [EXT_W-1:0] s1_ext;

  logic [NUM_CELLS-1:0] avg_valid;
  logic [NUM_CELLS-1:0] marks;
  logic [NUM_CELLS-1:0] marks_upd;

  logic [AVG_W-1:0]   rdata;
  logic [AVG_W-1:0]   old_avg;
  logic [ALPHA_W-1:0] a_c;
  logic signed [AVG_W:0]   diff;
  logic signed [AVG_W+ALPHA_W+1:0] prod;
  logic signed [AVG_W+ALPHA_W+1:0] step;
  logic [AVG_W-1:0]   new_avg;
  logic               fault_now;
  logic               we;

  logic              out_valid;
  logic [CELL_W-1:0] out_cell;
  logic [AVG_W-1:0]  out_filtered;
  logic              out_fault;
  logic              out_any;

  assign head_ext = EXT_W'(head_item.cell_id);
  assign s1_ext   = EXT_W'(s1_item.cell_id);
  assign head_idx = head_ext[IDX_W-1:0];
  assign s1_idx   = s1_ext[IDX_W-1:0];

  assign s1_fire = s1_valid && (!out_valid || m_tready);
  assign s1_load = head_valid && (!s1_valid || s1_fire);
  assign pop     = s1_load;
  assign we      = s1_fire && s1_item.in_range;

  cvf_ram #(
    .WIDTH (AVG_W),
    .DEPTH (NUM_CELLS)
  ) u_avg_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_idx),
    .wdata (new_avg),
    .re    (s1_load),
    .raddr (head_idx),
    .rdata (rdata)
  );

  // filter update: old + floor(min(alpha, 256) * (sample - old) / 256)
  always_comb begin
    a_c = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    if (byp) begin
      old_avg = byp_data;
    end else if (old_valid) begin
      old_avg = rdata;
    end else begin
      old_avg = '0;
    end
    diff      = $signed({1'b0, s1_item.sample_q}) - $signed({1'b0, old_avg});
    prod      = PROD_W'($signed({1'b0, a_c})) * PROD_W'(diff);
    step      = prod >>> FRAC_W;
    new_avg   = old_avg + step[AVG_W-1:0];
    fault_now = (new_avg < cfg.low_th) || (new_avg > cfg.high_th);
  end

  always_comb begin
    marks_upd = marks;
    if (s1_item.in_range) begin
      marks_upd[s1_idx] = fault_now;
    end
  end

  // s1 stage with same cell bypass from the write in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item   <= head_item;
      byp       <= we && (s1_idx == head_idx);
      byp_data  <= new_avg;
      old_valid <= avg_valid[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= '0;
      marks     <= '0;
    end else if (we) begin
      avg_valid[s1_idx] <= 1'b1;
      marks             <= marks_upd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cell     <= s1_item.cell_id;
      out_filtered <= s1_item.in_range ? new_avg : '0;
      out_fault    <= s1_item.in_range && fault_now;
      out_any      <= |marks_upd;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_any, out_fault, out_filtered, out_cell};

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (avg_valid == '0) && (marks == '0))
    else $error("state not cleared by reset");
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_item.in_range |=> (out_filtered == '0) && !out_fault)
    else $error("out of range cell produced data");
  a_fault_in_any: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_item.in_range && fault_now |=> out_any && (marks != '0))
    else $error("cell fault missing from any fault");
  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_filtered <= AVG_MAX)
    else $error("filtered value beyond full scale");

endmodule

### design/cell_voltage_filter_fault.sv
// top level of the cell voltage filter and window fault block
// depends on cvf_pkg, cvf_front, cvf_queue, cvf_back
//
// usage
//   input stream s_*: one transfer per cell reading, cell index and raw adc count
//   output stream m_*: one transfer per input transfer, in order, with the updated
//   per cell average (10.8 count units), the cell fault and the or of all cell faults
//   config port: cfg_we with cfg_index selects alpha, low threshold or high threshold;
//   write only while no transfer is in flight
//   latency: 2 cycles from input transfer to m_tvalid when the path is empty
//   throughput: one transfer per cycle, set by the single cycle multiply add per cell
//   with a bypass of the average being written back
//   reset: averages and fault marks read as zero, registers take their reset values
//   a stall on m_tready holds the output register; the input keeps taking transfers
//   until the two entry queue and the filter stage are full, then s_tready drops

module cell_voltage_filter_fault import cvf_pkg::*; #(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // cell_req[2:0], adc_count[12:3], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // cell_out[2:0], filtered[20:3],
                                           // cell_fault[21], any_fault[22], zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha   <= ALPHA_RESET;
      cfg.low_th  <= LOW_TH_RESET;
      cfg.high_th <= HIGH_TH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA:   cfg.alpha   <= cfg_data[ALPHA_W-1:0];
        REG_LOW_TH:  cfg.low_th  <= cfg_data;
        REG_HIGH_TH: cfg.high_th <= cfg_data;
        default: ;
      endcase
    end
  end

  cvf_front #(
    .NUM_CELLS (NUM_CELLS)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cvf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  cvf_back #(
    .NUM_CELLS (NUM_CELLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

### tb/cell_voltage_filter_fault_test.sv
`timescale 1ns / 1ps
// self-checking testbench for cell_voltage_filter_fault: directed, random and stall tests
// against a built-in per cell average and fault mark predictor
// depends on cvf_pkg and the cell_voltage_filter_fault rtl

module cell_voltage_filter_fault_test;
  import cvf_pkg::*;

  localparam int NCELLS      = NUM_CELLS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic [AVG_W-1:0]  filtered;
    logic              cell_fault;
    logic              any_fault;
  } reading_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // cell_req, adc_count, zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // cell_out, filtered, cell_fault, any_fault, zero pad
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // predictor state
  logic [AVG_W-1:0]   cell_avg [NCELLS];
  logic               cell_mark [NCELLS];
  logic [ALPHA_W-1:0] alpha_set;
  logic [AVG_W-1:0]   low_set;
  logic [AVG_W-1:0]   high_set;

  reading_result_t pending_readings[$];

  bit src_idle;
  bit sink_idle;
  int hold_cycles;
  int errors;
  int sent;
  int checked;
  int settings;
  int faults_seen;
  int cycles;

  cell_voltage_filter_fault #(.NUM_CELLS(NCELLS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cell_voltage_filter_fault_test NOT OK");
      $finish;
    end
  end

  function automatic reading_result_t filter_reading(input logic [CELL_W-1:0] cell_id,
                                                     input logic [ADC_W-1:0] adc);
    reading_result_t r;
    logic [ALPHA_W-1:0] a;
    logic [35:0] acc;
    logic any;
    r = '0;
    r.cell_id = cell_id;
    if (cell_id < NCELLS) begin
      a = (alpha_set > ALPHA_ONE) ? ALPHA_ONE : alpha_set;
      acc = 36'(a) * 36'({adc, 8'h00}) + 36'(ALPHA_ONE - a) * 36'(cell_avg[cell_id]);
      r.filtered = acc[AVG_W+7:8];
      r.cell_fault = (r.filtered < low_set) || (r.filtered > high_set);
      cell_avg[cell_id] = r.filtered;
      cell_mark[cell_id] = r.cell_fault;
    end
    any = 1'b0;
    for (int i = 0; i < NCELLS; i++) any |= cell_mark[i];
    r.any_fault = any;
    return r;
  endfunction

  task automatic send_reading(input logic [CELL_W-1:0] cell_id, input logic [ADC_W-1:0] adc);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {{(IN_DATA_W-CELL_W-ADC_W){1'b0}}, adc, cell_id};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_readings.push_back(filter_reading(cell_id, adc));
    sent++;
  endtask

  task automatic wait_results(input int extra);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_results(SETTLE);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ALPHA:   alpha_set = value[ALPHA_W-1:0];
      REG_LOW_TH:  low_set = value;
      REG_HIGH_TH: high_set = value;
      default: ;
    endcase
    settings++;
  endtask

  task automatic set_window(input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high);
    write_reg(REG_LOW_TH, low);
    write_reg(REG_HIGH_TH, high);
  endtask

  // extremes, alpha limits and saturation, window edges, crossed thresholds
  task automatic test_directed();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    send_reading(0, 1023);
    send_reading(7, 0);
    send_reading(0, 0);
    write_reg(REG_ALPHA, CFG_W'(ALPHA_ONE));
    send_reading(1, 1023);
    send_reading(2, 0);
    write_reg(REG_ALPHA, 18'd511);
    send_reading(3, 1023);
    write_reg(REG_ALPHA, 18'd257);
    send_reading(3, 0);
    write_reg(REG_ALPHA, 18'd0);
    send_reading(1, 0);
    send_reading(1, 1023);
    write_reg(REG_ALPHA, CFG_W'(ALPHA_ONE));
    set_window(18'd128000, 18'd200000);
    send_reading(4, 0);
    send_reading(4, 1023);
    send_reading(4, 500);
    send_reading(5, 781);
    send_reading(4, 782);
    send_reading(4, 600);
    set_window(18'd200000, 18'd128000);
    send_reading(6, 600);
    send_reading(6, 1023);
    set_window(18'h3FFFF, 18'h3FFFF);
    send_reading(0, 1023);
    set_window(18'd0, 18'd0);
    send_reading(0, 0);
    send_reading(0, 1);
    write_reg(REG_ALPHA, CFG_W'(ALPHA_RESET));
    set_window(LOW_TH_RESET, HIGH_TH_RESET);
    send_reading(2, 512);
  endtask

  task automatic random_setting();
    logic [CFG_W-1:0] low;
    logic [CFG_W-1:0] high;
    case ($urandom_range(0, 9))
      0: write_reg(REG_ALPHA, 0);
      1: write_reg(REG_ALPHA, CFG_W'(ALPHA_ONE));
      2: write_reg(REG_ALPHA, CFG_W'($urandom_range(257, 511)));
      default: write_reg(REG_ALPHA, CFG_W'($urandom_range(1, 255)));
    endcase
    case ($urandom_range(0, 7))
      0: begin
        low = LOW_TH_RESET;
        high = HIGH_TH_RESET;
      end
      1: begin
        low = CFG_W'($urandom_range(100000, 262143));
        high = CFG_W'($urandom_range(0, low - 1));
      end
      2: begin
        low = 18'h3FFFF;
        high = CFG_W'($urandom_range(0, 262143));
      end
      default: begin
        low = CFG_W'($urandom_range(20000, 120000));
        high = CFG_W'(low + $urandom_range(10000, 120000));
      end
    endcase
    if ($urandom_range(0, 1)) set_window(low, high);
    else begin
      write_reg(REG_HIGH_TH, high);
      write_reg(REG_LOW_TH, low);
    end
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [ADC_W-1:0] adc;
    for (int p = 0; p < phases; p++) begin
      random_setting();
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 7))
          0: adc = ADC_W'($urandom_range(0, 15));
          1: adc = ADC_W'($urandom_range(1008, 1023));
          2, 3: adc = ADC_W'($urandom_range(400, 624));
          default: adc = ADC_W'($urandom_range(0, 1023));
        endcase
        send_reading(CELL_W'($urandom_range(0, NCELLS - 1)), adc);
      end
    end
  endtask

  // receiver holds off long enough for the input to stall, then drains; random gaps on both sides follow
  task automatic test_output_stall();
    wait_results(SETTLE);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_cycles = 200;
    for (int n = 0; n < 40; n++) begin
      send_reading(CELL_W'($urandom_range(0, NCELLS - 1)), ADC_W'($urandom_range(0, 1023)));
    end
    wait_results(0);
    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (int n = 0; n < 30; n++) begin
      send_reading(CELL_W'($urandom_range(0, NCELLS - 1)), ADC_W'($urandom_range(0, 1023)));
    end
  endtask

  always @(posedge clk) begin : check_results
    reading_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      checked++;
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if (m_tdata[CELL_W-1:0] !== want.cell_id) begin
          $error("cell_out expected %0d got %0d", want.cell_id, m_tdata[CELL_W-1:0]);
          errors++;
        end
        if (m_tdata[CELL_W+AVG_W-1:CELL_W] !== want.filtered) begin
          $error("filtered expected %0d got %0d", want.filtered,
                 m_tdata[CELL_W+AVG_W-1:CELL_W]);
          errors++;
        end
        if (m_tdata[CELL_W+AVG_W] !== want.cell_fault) begin
          $error("cell_fault expected %0b got %0b", want.cell_fault, m_tdata[CELL_W+AVG_W]);
          errors++;
        end
        if (m_tdata[CELL_W+AVG_W+1] !== want.any_fault) begin
          $error("any_fault expected %0b got %0b", want.any_fault, m_tdata[CELL_W+AVG_W+1]);
          errors++;
        end
        if (want.cell_fault) faults_seen++;
      end
    end
  end

  initial begin : sink
    int stall;
    bit hold_done;
    m_tready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0 && !hold_done) begin
        m_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_done = 1'b1;
      end
      stall = sink_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid && (hold_cycles == 0 || hold_done));
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data = '0;
    sent = 0;
    settings = 0;
    hold_cycles = 0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    alpha_set = ALPHA_RESET;
    low_set = LOW_TH_RESET;
    high_set = HIGH_TH_RESET;
    for (int i = 0; i < NCELLS; i++) begin
      cell_avg[i] = '0;
      cell_mark[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(6, 155);
    test_output_stall();
    test_random(6, 155);
    wait_results(20);

    if (pending_readings.size() != 0) begin
      $error("%0d results never arrived", pending_readings.size());
    end
    $display("%0d readings, %0d results checked (%0d with cell fault), %0d register writes",
             sent, checked, faults_seen, settings);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("cell_voltage_filter_fault_test OK");
    end else begin
      $display("cell_voltage_filter_fault_test NOT OK");
    end
    $finish;
  end

endmodule
